@@ sv/bchc_pkg.sv @@
// Package: types, constants and codes shared by the charge hysteresis controller.
`timescale 1ns / 1ps

package bchc_pkg;

  // Field widths
  localparam int unsigned MV_W       = 15;
  localparam int unsigned SOC_W      = 32;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  // Signed width for the voltage-mode sums (15-bit target plus a band, with sign)
  localparam int unsigned VSUM_W     = 18;

  // Thresholds
  localparam logic [SOC_W-1:0]  SOC_SCALE        = 32'd10080;  // 280 * 36
  localparam logic [SOC_W-1:0]  SOC_BAND         = 32'd5038;   // 4999 * 28 * 36 / 1000
  localparam logic [TEMP_W-1:0] MIN_CHARGE_TEMP  = 16'sd1280;  // 5.0 in 8.8
  localparam logic [MV_W-1:0]   FULL_PACK_MV     = 15'd14000;
  localparam logic [MV_W-1:0]   EMPTY_PACK_MV    = 15'd10000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_ENABLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SOC       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CELL_MV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REBOUND_MV       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INFLECTION_MV    = 3'd6;

  // Target modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_SOC     = 2'd1;
  localparam logic [1:0] MODE_VOLTAGE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_NEUTRAL        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_CHARGING       = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_CHARGE_HELD    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DISCHARGING    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DISCHARGE_HELD = 3'd4;

  // Reset values of the registers
  localparam logic [6:0]  RST_TARGET_SOC     = 7'd50;
  localparam logic [12:0] RST_TARGET_CELL_MV = 13'd3300;
  localparam logic [7:0]  RST_REBOUND_MV     = 8'sd10;
  localparam logic [6:0]  RST_INFLECTION_MV  = 7'd15;

  typedef enum logic [1:0] {
    ST_NEUTRAL   = 2'd0,
    ST_CHARGE    = 2'd1,
    ST_DISCHARGE = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]        target_mode;
    logic              charge_enable;
    logic              discharge_enable;
    logic [6:0]        target_soc;
    logic [12:0]       target_cell_mv;
    logic signed [7:0] rebound_mv;
    logic [6:0]        inflection_mv;
  } cfg_regs_t;

  typedef struct packed {
    state_t              state;
    logic                allowed;
    logic                charge_on;
    logic                supply_cut;
    logic [STATUS_W-1:0] status_code;
  } step_t;

endpackage

@@ sv/bchc_decide.sv @@
// Next-state, drive and status logic for one item of the hysteresis controller.
`timescale 1ns / 1ps

module bchc_decide (
  input  bchc_pkg::cfg_regs_t                  cfg,
  input  bchc_pkg::state_t                     state_cur,
  input  logic                                 allowed_cur,
  input  logic [bchc_pkg::MV_W-1:0]            battery_mv,
  input  logic [bchc_pkg::SOC_W-1:0]           soc_amp_seconds,
  input  logic signed [bchc_pkg::TEMP_W-1:0]   temperature,
  output bchc_pkg::step_t                      step
);

  logic [bchc_pkg::SOC_W-1:0]         soc_tgt;
  logic [bchc_pkg::SOC_W-1:0]         soc_cstart;
  logic [bchc_pkg::SOC_W-1:0]         soc_dstart;
  logic signed [bchc_pkg::VSUM_W-1:0] v_mv;
  logic signed [bchc_pkg::VSUM_W-1:0] v_tgt;
  logic signed [bchc_pkg::VSUM_W-1:0] v_entry;
  logic signed [bchc_pkg::VSUM_W-1:0] v_exit;
  bchc_pkg::state_t                   state_nxt;
  logic                               allowed_nxt;
  logic                               chg_ok;
  logic                               dis_ok;

  assign soc_tgt    = {25'd0, cfg.target_soc} * bchc_pkg::SOC_SCALE;
  assign soc_cstart = soc_tgt - bchc_pkg::SOC_BAND;  // wraps for a zero target
  assign soc_dstart = soc_tgt + bchc_pkg::SOC_BAND;

  assign v_mv    = $signed({3'd0, battery_mv});
  assign v_tgt   = $signed({3'd0, cfg.target_cell_mv, 2'b00});
  assign v_entry = $signed({9'd0, cfg.inflection_mv, 2'b00});
  assign v_exit  = $signed({{8{cfg.rebound_mv[7]}}, cfg.rebound_mv, 2'b00});

  assign chg_ok = ($signed(temperature) >= $signed(bchc_pkg::MIN_CHARGE_TEMP)) &&
                  (battery_mv < bchc_pkg::FULL_PACK_MV) && cfg.charge_enable;
  assign dis_ok = (battery_mv > bchc_pkg::EMPTY_PACK_MV) && cfg.discharge_enable;

  always_comb begin
    state_nxt = state_cur;
    if (battery_mv == '0) begin
      state_nxt = state_cur;  // invalid voltage: hold
    end else if (cfg.target_mode == bchc_pkg::MODE_SOC) begin
      unique case (state_cur)
        bchc_pkg::ST_NEUTRAL: begin
          // charge test last so it wins
          if (soc_amp_seconds >= soc_dstart) state_nxt = bchc_pkg::ST_DISCHARGE;
          if (soc_amp_seconds <= soc_cstart) state_nxt = bchc_pkg::ST_CHARGE;
        end
        bchc_pkg::ST_CHARGE: begin
          if (soc_amp_seconds >= soc_tgt) state_nxt = bchc_pkg::ST_NEUTRAL;
        end
        bchc_pkg::ST_DISCHARGE: begin
          if (soc_amp_seconds <= soc_tgt) state_nxt = bchc_pkg::ST_NEUTRAL;
        end
        default: state_nxt = state_cur;
      endcase
    end else if (cfg.target_mode == bchc_pkg::MODE_VOLTAGE) begin
      unique case (state_cur)
        bchc_pkg::ST_NEUTRAL: begin
          if (v_mv >= v_tgt + v_entry) state_nxt = bchc_pkg::ST_DISCHARGE;
          if (v_mv <= v_tgt - v_entry) state_nxt = bchc_pkg::ST_CHARGE;
        end
        bchc_pkg::ST_CHARGE: begin
          if (v_mv >= v_tgt + v_exit) state_nxt = bchc_pkg::ST_NEUTRAL;
        end
        bchc_pkg::ST_DISCHARGE: begin
          if (v_mv <= v_tgt - v_exit) state_nxt = bchc_pkg::ST_NEUTRAL;
        end
        default: state_nxt = state_cur;
      endcase
    end else begin
      state_nxt = bchc_pkg::ST_NEUTRAL;
    end
  end

  always_comb begin
    allowed_nxt     = allowed_cur;
    step.charge_on  = 1'b0;
    step.supply_cut = 1'b0;
    if (battery_mv != '0) begin
      if (state_nxt == bchc_pkg::ST_CHARGE) begin
        allowed_nxt    = chg_ok;
        step.charge_on = chg_ok;
      end else if (state_nxt == bchc_pkg::ST_DISCHARGE) begin
        allowed_nxt     = dis_ok;
        step.supply_cut = dis_ok;
      end
    end
    step.state   = state_nxt;
    step.allowed = allowed_nxt;
    unique case (state_nxt)
      bchc_pkg::ST_CHARGE:
        step.status_code = allowed_nxt ? bchc_pkg::STAT_CHARGING
                                       : bchc_pkg::STAT_CHARGE_HELD;
      bchc_pkg::ST_DISCHARGE:
        step.status_code = allowed_nxt ? bchc_pkg::STAT_DISCHARGING
                                       : bchc_pkg::STAT_DISCHARGE_HELD;
      default:
        step.status_code = bchc_pkg::STAT_NEUTRAL;
    endcase
  end

endmodule

@@ sv/battery_charge_hysteresis_control.sv @@
// Top level: battery charge/discharge hysteresis controller with item handshakes.
// Path: an accepted item passes through the input register, then the result register;
//   a stalled result (out_ready low) holds the item in each.
// Throughput: one item per cycle while the result is not stalled; the state register
//   updates as an item moves from the input register into the result register.
// Reset (rst_n low, synchronous): both stages empty, state neutral, allowed flag
//   clear, registers at their reset values. cfg_ready is always high.
`timescale 1ns / 1ps

module battery_charge_hysteresis_control (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bchc_pkg::MV_W-1:0]            in_battery_mv,
  input  logic [bchc_pkg::SOC_W-1:0]           in_soc_amp_seconds,
  input  logic signed [bchc_pkg::TEMP_W-1:0]   in_temperature,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_charge_on,
  output logic                                 out_supply_cut,
  output logic [bchc_pkg::STATUS_W-1:0]        out_status_code,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bchc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bchc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bchc_pkg::cfg_regs_t                 cfg_r;
  bchc_pkg::state_t                    state_r;
  logic                                allowed_r;
  logic                                s1_valid_r;
  logic [bchc_pkg::MV_W-1:0]           s1_mv_r;
  logic [bchc_pkg::SOC_W-1:0]          s1_soc_r;
  logic signed [bchc_pkg::TEMP_W-1:0]  s1_temp_r;
  logic                                out_valid_r;
  logic                                out_charge_on_r;
  logic                                out_supply_cut_r;
  logic [bchc_pkg::STATUS_W-1:0]       out_status_r;
  logic                                advance;
  bchc_pkg::step_t                     step;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_mode      <= bchc_pkg::MODE_OFF;
      cfg_r.charge_enable    <= 1'b0;
      cfg_r.discharge_enable <= 1'b0;
      cfg_r.target_soc       <= bchc_pkg::RST_TARGET_SOC;
      cfg_r.target_cell_mv   <= bchc_pkg::RST_TARGET_CELL_MV;
      cfg_r.rebound_mv       <= bchc_pkg::RST_REBOUND_MV;
      cfg_r.inflection_mv    <= bchc_pkg::RST_INFLECTION_MV;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bchc_pkg::REG_TARGET_MODE:      cfg_r.target_mode      <= cfg_data[1:0];
        bchc_pkg::REG_CHARGE_ENABLE:    cfg_r.charge_enable    <= cfg_data[0];
        bchc_pkg::REG_DISCHARGE_ENABLE: cfg_r.discharge_enable <= cfg_data[0];
        bchc_pkg::REG_TARGET_SOC:       cfg_r.target_soc       <= cfg_data[6:0];
        bchc_pkg::REG_TARGET_CELL_MV:   cfg_r.target_cell_mv   <= cfg_data[12:0];
        bchc_pkg::REG_REBOUND_MV:       cfg_r.rebound_mv       <= cfg_data[7:0];
        bchc_pkg::REG_INFLECTION_MV:    cfg_r.inflection_mv    <= cfg_data[6:0];
        default: ;  // unused index: ignored
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mv_r   <= in_battery_mv;
      s1_soc_r  <= in_soc_amp_seconds;
      s1_temp_r <= in_temperature;
    end
  end

  bchc_decide u_decide (
    .cfg             (cfg_r),
    .state_cur       (state_r),
    .allowed_cur     (allowed_r),
    .battery_mv      (s1_mv_r),
    .soc_amp_seconds (s1_soc_r),
    .temperature     (s1_temp_r),
    .step            (step)
  );

  // Controller state, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bchc_pkg::ST_NEUTRAL;
      allowed_r <= 1'b0;
    end else if (advance) begin
      state_r   <= step.state;
      allowed_r <= step.allowed;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_charge_on_r  <= step.charge_on;
      out_supply_cut_r <= step.supply_cut;
      out_status_r     <= step.status_code;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_charge_on   = out_charge_on_r;
  assign out_supply_cut  = out_supply_cut_r;
  assign out_status_code = out_status_r;

endmodule

@@ sv/bchc_checker.sv @@
// Port-level checker for the charge hysteresis controller, bound to the top level.
`timescale 1ns / 1ps

module bchc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_charge_on,
  input logic                           out_supply_cut,
  input logic [bchc_pkg::STATUS_W-1:0]  out_status_code
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable(out_charge_on) && $stable(out_supply_cut) && $stable(out_status_code))
    else $error("result changed while stalled");

  // Nothing is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The charger drive only comes with the charging status.
  a_charge_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_charge_on |-> out_status_code == bchc_pkg::STAT_CHARGING)
    else $error("charge drive without charging status");

  // Supply cut only with the discharging status.
  a_supply_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_supply_cut |-> out_status_code == bchc_pkg::STAT_DISCHARGING)
    else $error("supply cut without discharging status");

  // Never both drives, and no status code past the last one.
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_charge_on && out_supply_cut) &&
      out_status_code <= bchc_pkg::STAT_DISCHARGE_HELD)
    else $error("both drives on or bad status code");

endmodule

bind battery_charge_hysteresis_control bchc_checker u_bchc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_charge_on   (out_charge_on),
  .out_supply_cut  (out_supply_cut),
  .out_status_code (out_status_code)
);
